/* design/vppg_pkg.sv */
// Shared types and constants for the voxel piece placement grid.
// No dependencies; every other file in the block imports this package.
package vppg_pkg;

    // Number of offset fields carried by one request.
    localparam int OFFSET_FIELDS = 5;

    // Configuration register indexes.
    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_DEPTH  = 2'd1;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        MODE_CHECK  = 2'd0,
        MODE_PUT    = 2'd1,
        MODE_REMOVE = 2'd2
    } mode_t;

    // Configured grid extents, one per axis.
    typedef struct packed {
        logic [2:0] w;
        logic [2:0] d;
        logic [2:0] h;
    } ext_t;

    // What one block lane found for its offset.
    typedef struct packed {
        logic active;
        logic inb;
        logic busy;
    } lane_stat_t;

    // Record written into a claimed cell.
    typedef struct packed {
        logic [3:0] owner;
        logic [5:0] origin;
        logic [4:0] orientation;
    } rec_t;

endpackage

/* design/vppg_lane.sv */
// One block lane: forms the cell coordinate, tests it against the extents
// and looks up its occupied bit. Depends on vppg_pkg.
module vppg_lane #(
    parameter int GRID_DIM = 4,
    parameter int LANE     = 0,
    parameter int IDX_W    = 6
) (
    input  vppg_pkg::ext_t              ext,
    input  logic [1:0]                  origin_x,
    input  logic [1:0]                  origin_y,
    input  logic [1:0]                  origin_z,
    input  logic [5:0]                  offset,
    input  logic [2:0]                  block_count,
    input  logic [GRID_DIM**3-1:0]      occ,
    output vppg_pkg::lane_stat_t        stat,
    output logic [IDX_W-1:0]            idx
);
    import vppg_pkg::*;

    localparam int FLAT_W = IDX_W + 3;

    logic [2:0]        cx;
    logic [2:0]        cy;
    logic [2:0]        cz;
    logic [3:0]        eff_x;
    logic [3:0]        eff_y;
    logic [3:0]        eff_z;
    logic [FLAT_W-1:0] flat;

    // Extents above the grid size count as the grid size.
    always_comb
    begin
        eff_x = ({1'b0, ext.w} > 4'(GRID_DIM)) ? 4'(GRID_DIM) : {1'b0, ext.w};
        eff_y = ({1'b0, ext.d} > 4'(GRID_DIM)) ? 4'(GRID_DIM) : {1'b0, ext.d};
        eff_z = ({1'b0, ext.h} > 4'(GRID_DIM)) ? 4'(GRID_DIM) : {1'b0, ext.h};
    end

    assign cx = {1'b0, origin_x} + {1'b0, offset[1:0]};
    assign cy = {1'b0, origin_y} + {1'b0, offset[3:2]};
    assign cz = {1'b0, origin_z} + {1'b0, offset[5:4]};

    assign flat = FLAT_W'(cx) + FLAT_W'(GRID_DIM)
                * (FLAT_W'(cy) + FLAT_W'(GRID_DIM) * FLAT_W'(cz));
    assign idx  = flat[IDX_W-1:0];

    always_comb
    begin
        stat.active = 3'(LANE) < block_count;
        stat.inb    = ({1'b0, cx} < eff_x) && ({1'b0, cy} < eff_y)
                   && ({1'b0, cz} < eff_z);
        // Only look at the grid when the index is known to be in range.
        stat.busy   = stat.inb ? occ[idx] : 1'b0;
    end

endmodule

/* design/vppg_merge.sv */
// Merging stage: folds the lane findings into the fits flag and the per-lane
// claim and clear enables. Depends on vppg_pkg.
module vppg_merge #(
    parameter int LANES = 5
) (
    input  logic                 go,
    input  logic [1:0]           mode,
    input  vppg_pkg::lane_stat_t stat [LANES],
    output logic                 fits,
    output logic [LANES-1:0]     set_en,
    output logic [LANES-1:0]     clr_en
);
    import vppg_pkg::*;

    logic chk_ok;

    always_comb
    begin
        chk_ok = 1'b1;
        for (int i = 0; i < LANES; i++)
        begin
            if (stat[i].active && (!stat[i].inb || stat[i].busy))
                chk_ok = 1'b0;
        end
    end

    always_comb
    begin
        fits = (mode == MODE_REMOVE) ? 1'b1 : chk_ok;
        for (int i = 0; i < LANES; i++)
        begin
            set_en[i] = go && (mode == MODE_PUT) && chk_ok
                     && stat[i].active && stat[i].inb;
            clr_en[i] = go && (mode == MODE_REMOVE)
                     && stat[i].active && stat[i].inb;
        end
    end

endmodule

/* design/vppg_grid.sv */
// Grid storage: occupied bits in flops, cleared by reset, and one record
// memory bank per lane for owner, origin and rotation. Depends on vppg_pkg.
module vppg_grid #(
    parameter int CELLS = 64,
    parameter int LANES = 5,
    parameter int IDX_W = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [LANES-1:0]             set_en,
    input  logic [LANES-1:0]             clr_en,
    input  logic [LANES-1:0][IDX_W-1:0]  idx,
    input  vppg_pkg::rec_t               rec,
    output logic [CELLS-1:0]             occ
);
    import vppg_pkg::*;

    logic [CELLS-1:0] occ_reg;
    logic [CELLS-1:0] occ_next;

    // A request either claims or clears, never both, so lane order is moot.
    always_comb
    begin
        occ_next = occ_reg;
        for (int i = 0; i < LANES; i++)
        begin
            if (clr_en[i])
                occ_next[idx[i]] = 1'b0;
            if (set_en[i])
                occ_next[idx[i]] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

    assign occ = occ_reg;

    // One write port per bank; the bank of the lane that claimed a cell last
    // holds its current record.
    for (genvar g = 0; g < LANES; g++)
    begin : g_bank
        rec_t bank [CELLS];

        always_ff @(posedge clk)
        begin
            if (set_en[g])
                bank[idx[g]] <= rec;
        end
    end

endmodule

/* design/voxel_piece_placement_grid_core.sv */
// Top level of the voxel piece placement grid: configuration registers,
// request handshake, block lanes, merge and grid storage.
// Depends on vppg_pkg, vppg_lane, vppg_merge and vppg_grid.
//
//   channel   signals                               direction
//   --------  ------------------------------------  ---------
//   request   in_valid / in_ready, mode .. offset_4  in
//   result    out_valid / out_ready, fits           out
//   config    cfg_we, cfg_index, cfg_data           in
//
// One request per cycle while in_ready is high: the lanes read the flop
// occupancy vector, the merge decides, and the grid updates at the same edge
// that loads the result. The next request sees the updated grid with no gap.
// Reset clears every occupied bit at once; no sweep follows.
// in_ready drops only while a result is held and out_ready is low.
module voxel_piece_placement_grid_core #(
    parameter int GRID_DIM   = 4,
    parameter int MAX_BLOCKS = 5
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] mode,
    input  logic [3:0] piece_id,
    input  logic [4:0] orientation,
    input  logic [1:0] origin_x,
    input  logic [1:0] origin_y,
    input  logic [1:0] origin_z,
    input  logic [2:0] block_count,
    input  logic [5:0] offset_0,
    input  logic [5:0] offset_1,
    input  logic [5:0] offset_2,
    input  logic [5:0] offset_3,
    input  logic [5:0] offset_4,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       fits,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [2:0] cfg_data
);
    import vppg_pkg::*;

    localparam int CELLS = GRID_DIM * GRID_DIM * GRID_DIM;
    localparam int IDX_W = $clog2(CELLS);
    localparam int LANES = (MAX_BLOCKS < OFFSET_FIELDS) ? MAX_BLOCKS : OFFSET_FIELDS;

    ext_t                        ext_reg;
    ext_t                        ext_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        fits_reg;
    logic                        fits_next;
    logic                        in_accept;
    logic [5:0]                  offs [OFFSET_FIELDS];
    lane_stat_t                  lane_stat [LANES];
    logic [LANES-1:0][IDX_W-1:0] lane_idx;
    logic [LANES-1:0]            set_en;
    logic [LANES-1:0]            clr_en;
    logic [CELLS-1:0]            occ_vec;
    rec_t                        rec;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    assign offs[0] = offset_0;
    assign offs[1] = offset_1;
    assign offs[2] = offset_2;
    assign offs[3] = offset_3;
    assign offs[4] = offset_4;

    assign rec.owner       = piece_id;
    assign rec.origin      = {origin_z, origin_y, origin_x};
    assign rec.orientation = orientation;

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        vppg_lane #(
            .GRID_DIM (GRID_DIM),
            .LANE     (g),
            .IDX_W    (IDX_W)
        ) u_lane (
            .ext         (ext_reg),
            .origin_x    (origin_x),
            .origin_y    (origin_y),
            .origin_z    (origin_z),
            .offset      (offs[g]),
            .block_count (block_count),
            .occ         (occ_vec),
            .stat        (lane_stat[g]),
            .idx         (lane_idx[g])
        );
    end

    vppg_merge #(
        .LANES (LANES)
    ) u_merge (
        .go     (in_accept),
        .mode   (mode),
        .stat   (lane_stat),
        .fits   (fits_next),
        .set_en (set_en),
        .clr_en (clr_en)
    );

    vppg_grid #(
        .CELLS (CELLS),
        .LANES (LANES),
        .IDX_W (IDX_W)
    ) u_grid (
        .clk    (clk),
        .rst_n  (rst_n),
        .set_en (set_en),
        .clr_en (clr_en),
        .idx    (lane_idx),
        .rec    (rec),
        .occ    (occ_vec)
    );

    // Configuration writes; an index past the list is dropped.
    always_comb
    begin
        ext_next = ext_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:  ext_next.w = cfg_data;
                REG_GRID_DEPTH:  ext_next.d = cfg_data;
                REG_GRID_HEIGHT: ext_next.h = cfg_data;
                default:         ext_next = ext_reg;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg       <= '{w: 3'd4, d: 3'd4, h: 3'd4};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ext_reg       <= ext_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            fits_reg <= fits_next;
    end

    assign out_valid = out_valid_reg;
    assign fits      = fits_reg;

    // Remove always reports a fit.
    a_remove_fits: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (mode == MODE_REMOVE) |=> fits)
        else $error("remove reported no fit");

    // Check, unused mode and a failed put leave the grid alone.
    a_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (mode != MODE_REMOVE) && !((mode == MODE_PUT) && fits_next)
        |=> $stable(occ_vec))
        else $error("grid changed without a successful put or remove");

    // A successful put claims the cell of its first block.
    a_put_claims: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (mode == MODE_PUT) && fits_next && lane_stat[0].active
        |=> occ_vec[$past(lane_idx[0])])
        else $error("put did not claim its first cell");

endmodule

/* tb/tb_voxel_piece_placement_grid_core.sv */
// Self-checking testbench for voxel_piece_placement_grid_core. A shadow copy of the
// occupancy grid predicts the fits flag of every accepted request.
// Depends on vppg_pkg and the design sources of the block.
module tb_voxel_piece_placement_grid_core;
    timeunit 1ns;
    timeprecision 1ps;

    import vppg_pkg::*;

    localparam int GRID_DIM    = 4;
    localparam int MAX_BLOCKS  = 5;
    localparam int LANES       = (MAX_BLOCKS < OFFSET_FIELDS) ? MAX_BLOCKS : OFFSET_FIELDS;
    localparam int CELLS       = GRID_DIM * GRID_DIM * GRID_DIM;
    localparam int QUIET_LIMIT = 4000;
    localparam int REPORT_MAX  = 10;
    localparam int HISTORY_MAX = 24;
    localparam int PHASES      = 8;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Extents and request counts of the random phases.
    localparam int PLAN_W [PHASES] = '{4, 1, 7, 2, 4, 0, 3, 4};
    localparam int PLAN_D [PHASES] = '{4, 1, 7, 3, 1, 0, 4, 2};
    localparam int PLAN_H [PHASES] = '{4, 1, 7, 4, 2, 0, 2, 3};
    localparam int PLAN_N [PHASES] = '{250, 200, 250, 250, 250, 60, 250, 250};

    typedef struct packed {
        logic [1:0]                    mode;
        logic [3:0]                    piece;
        logic [4:0]                    orient;
        logic [1:0]                    ox;
        logic [1:0]                    oy;
        logic [1:0]                    oz;
        logic [2:0]                    count;
        logic [OFFSET_FIELDS-1:0][5:0] offs;
    } request_t;

    class grid_shadow;
        bit       occupied [CELLS];
        bit [2:0] ext_w;
        bit [2:0] ext_d;
        bit [2:0] ext_h;
        bit       fits_due [$];
        int       failures;
        int       n_check;
        int       n_put;
        int       n_placed;
        int       n_remove;

        function new();
            foreach (occupied[i])
                occupied[i] = 1'b0;
            ext_w    = 3'd4;
            ext_d    = 3'd4;
            ext_h    = 3'd4;
            failures = 0;
            n_check  = 0;
            n_put    = 0;
            n_placed = 0;
            n_remove = 0;
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= REPORT_MAX)
                $display("[%0t] %s", $time, msg);
        endfunction

        function void set_extent(logic [1:0] index, logic [2:0] value);
            case (index)
                REG_GRID_WIDTH:  ext_w = value;
                REG_GRID_DEPTH:  ext_d = value;
                REG_GRID_HEIGHT: ext_h = value;
                default: ;
            endcase
        endfunction

        function int clamp(bit [2:0] e);
            return (e > GRID_DIM) ? GRID_DIM : int'(e);
        endfunction

        // Map one block lane to a cell; return 0 when it falls outside the extents.
        function bit locate(request_t r, int lane, output int cell_no);
            int cx;
            int cy;
            int cz;
            cx = int'(r.ox) + int'(r.offs[lane][1:0]);
            cy = int'(r.oy) + int'(r.offs[lane][3:2]);
            cz = int'(r.oz) + int'(r.offs[lane][5:4]);
            cell_no = cx + GRID_DIM * (cy + GRID_DIM * cz);
            return (cx < clamp(ext_w)) && (cy < clamp(ext_d)) && (cz < clamp(ext_h));
        endfunction

        function void note_request(request_t r);
            int used;
            int cell_no;
            bit ok;
            used = (r.count > LANES) ? LANES : int'(r.count);
            ok   = 1'b1;
            if (r.mode == MODE_REMOVE) begin
                n_remove++;
                for (int i = 0; i < used; i++)
                    if (locate(r, i, cell_no))
                        occupied[cell_no] = 1'b0;
            end
            else begin
                // Test every used lane against the grid as it stood before this request.
                for (int i = 0; i < used; i++)
                    if (!locate(r, i, cell_no) || occupied[cell_no])
                        ok = 1'b0;
                if (r.mode == MODE_PUT) begin
                    n_put++;
                    if (ok) begin
                        n_placed++;
                        for (int i = 0; i < used; i++)
                            if (locate(r, i, cell_no))
                                occupied[cell_no] = 1'b1;
                    end
                end
                else begin
                    n_check++;
                end
            end
            fits_due.push_back(ok);
        endfunction

        function void check_fits(logic actual);
            bit expected;
            if (fits_due.size() == 0) begin
                flag($sformatf("result fits=%0b with no request outstanding", actual));
                return;
            end
            expected = fits_due.pop_front();
            if (actual !== expected)
                flag($sformatf("fits mismatch: expected %0b, got %0b", expected, actual));
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] mode;
    logic [3:0] piece_id;
    logic [4:0] orientation;
    logic [1:0] origin_x;
    logic [1:0] origin_y;
    logic [1:0] origin_z;
    logic [2:0] block_count;
    logic [5:0] offset_0;
    logic [5:0] offset_1;
    logic [5:0] offset_2;
    logic [5:0] offset_3;
    logic [5:0] offset_4;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       fits;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = 2'd0;
    logic [2:0] cfg_data = 3'd0;

    request_t   drv = '0;
    int         tx_idle_pct = 0;
    int         rx_stall_pct = 0;
    int         quiet_cycles = 0;
    request_t   placed_log [$];
    grid_shadow shadow = new();

    assign mode        = drv.mode;
    assign piece_id    = drv.piece;
    assign orientation = drv.orient;
    assign origin_x    = drv.ox;
    assign origin_y    = drv.oy;
    assign origin_z    = drv.oz;
    assign block_count = drv.count;
    assign offset_0    = drv.offs[0];
    assign offset_1    = drv.offs[1];
    assign offset_2    = drv.offs[2];
    assign offset_3    = drv.offs[3];
    assign offset_4    = drv.offs[4];

    voxel_piece_placement_grid_core #(
        .GRID_DIM   (GRID_DIM),
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_top (.*);

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(negedge clk)
    begin
        out_ready = ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready)
                shadow.note_request(drv);
            if (out_valid && out_ready)
                shadow.check_fits(fits);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial
    begin
        do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
        $display("watchdog: no request or result moved for %0d cycles", QUIET_LIMIT);
        $display("voxel_piece_placement_grid_core regression: fail");
        $finish;
    end

    task automatic send(request_t r);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        drv      = r;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    // Hold the sender off until every outstanding result has come back.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (shadow.fits_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_extents(logic [2:0] w, logic [2:0] d, logic [2:0] h);
        logic [1:0] regs [3];
        logic [2:0] vals [3];
        regs = '{REG_GRID_WIDTH, REG_GRID_DEPTH, REG_GRID_HEIGHT};
        vals = '{w, d, h};
        for (int i = 0; i < 3; i++) begin
            @(negedge clk);
            cfg_we    = 1'b1;
            cfg_index = regs[i];
            cfg_data  = vals[i];
            shadow.set_extent(regs[i], vals[i]);
        end
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic request_t make_item(logic [1:0] m, logic [3:0] pc, logic [4:0] orn,
                                           logic [1:0] x, logic [1:0] y, logic [1:0] z,
                                           logic [2:0] cnt, logic [5:0] o0, logic [5:0] o1,
                                           logic [5:0] o2, logic [5:0] o3, logic [5:0] o4);
        request_t r;
        r.mode   = m;
        r.piece  = pc;
        r.orient = orn;
        r.ox     = x;
        r.oy     = y;
        r.oz     = z;
        r.count  = cnt;
        r.offs   = {o4, o3, o2, o1, o0};
        return r;
    endfunction

    // Build a connected piece by walking one step per block from a small base.
    function automatic request_t shape_request(logic [1:0] m);
        request_t r;
        int       x;
        int       y;
        int       z;
        r.mode   = m;
        r.piece  = 4'($urandom_range(0, 15));
        r.orient = 5'($urandom_range(0, 31));
        r.ox     = 2'($urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(0, 3));
        r.oy     = 2'($urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(0, 3));
        r.oz     = 2'($urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(0, 3));
        r.count  = 3'($urandom_range(1, LANES));
        x = $urandom_range(0, 1);
        y = $urandom_range(0, 1);
        z = $urandom_range(0, 1);
        for (int i = 0; i < OFFSET_FIELDS; i++) begin
            if (i < r.count) begin
                r.offs[i] = {z[1:0], y[1:0], x[1:0]};
                // A step that would leave the offset range repeats the cell.
                case ($urandom_range(0, 2))
                    0: if (x < 3) x++;
                    1: if (y < 3) y++;
                    default: if (z < 3) z++;
                endcase
            end
            else begin
                r.offs[i] = 6'($urandom_range(0, 63));
            end
        end
        return r;
    endfunction

    function automatic request_t noise_request();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(request_t)-1:0];
    endfunction

    initial
    begin
        request_t a;
        request_t r;
        int       pick;
        int       slot;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        a = make_item(MODE_PUT, 4'd2, 5'd5, 2'd0, 2'd0, 2'd0, 3'd5, 6'd0, 6'd1, 6'd4, 6'd16, 6'd5);
        send(make_item(MODE_CHECK, 4'd0, 5'd0, 2'd0, 2'd0, 2'd0, 3'd0, 6'd0, 6'd0, 6'd0, 6'd0,
                       6'd0));
        send(make_item(MODE_PUT, 4'd1, 5'd1, 2'd3, 2'd3, 2'd3, 3'd0, 6'd63, 6'd63, 6'd63,
                       6'd63, 6'd63));
        send(a);
        a.mode = MODE_CHECK;
        send(a);
        send(make_item(MODE_SPARE, 4'd3, 5'd0, 2'd2, 2'd2, 2'd2, 3'd1, 6'd0, 6'd0, 6'd0, 6'd0,
                       6'd0));
        send(make_item(MODE_PUT, 4'd3, 5'd0, 2'd2, 2'd2, 2'd2, 3'd1, 6'd0, 6'd0, 6'd0, 6'd0,
                       6'd0));
        // Same cell named three times within one put.
        send(make_item(MODE_PUT, 4'd4, 5'd7, 2'd1, 2'd2, 2'd0, 3'd3, 6'd0, 6'd0, 6'd0, 6'd9,
                       6'd9));
        send(make_item(MODE_CHECK, 4'd0, 5'd0, 2'd1, 2'd2, 2'd0, 3'd1, 6'd0, 6'd0, 6'd0, 6'd0,
                       6'd0));
        send(make_item(MODE_PUT, 4'd5, 5'd0, 2'd3, 2'd3, 2'd3, 3'd1, 6'd63, 6'd0, 6'd0, 6'd0,
                       6'd0));
        // Counts above the lane count saturate.
        send(make_item(MODE_PUT, 4'd6, 5'd0, 2'd0, 2'd3, 2'd3, 3'd7, 6'd0, 6'd1, 6'd2, 6'd3,
                       6'd63));
        send(make_item(MODE_PUT, 4'd6, 5'd0, 2'd0, 2'd3, 2'd3, 3'd6, 6'd0, 6'd1, 6'd2, 6'd3,
                       6'd0));
        send(make_item(MODE_REMOVE, 4'd9, 5'd0, 2'd3, 2'd3, 2'd3, 3'd7, 6'd0, 6'd63, 6'd63,
                       6'd63, 6'd63));
        // Remove under a different owner id still clears the cells.
        send(make_item(MODE_REMOVE, 4'd9, 5'd31, 2'd0, 2'd0, 2'd0, 3'd5, 6'd0, 6'd1, 6'd4,
                       6'd16, 6'd5));
        send(a);
        send(make_item(MODE_PUT, 4'd15, 5'd31, 2'd3, 2'd3, 2'd3, 3'd1, 6'd0, 6'd0, 6'd0, 6'd0,
                       6'd0));
        send(make_item(MODE_CHECK, 4'd15, 5'd31, 2'd3, 2'd3, 2'd3, 3'd1, 6'd0, 6'd0, 6'd0,
                       6'd0, 6'd0));
        send(make_item(MODE_REMOVE, 4'd0, 5'd0, 2'd0, 2'd3, 2'd3, 3'd5, 6'd0, 6'd1, 6'd2,
                       6'd3, 6'd0));
        send(make_item(MODE_CHECK, 4'd0, 5'd0, 2'd0, 2'd3, 2'd3, 3'd4, 6'd0, 6'd1, 6'd2, 6'd3,
                       6'd0));
        send(make_item(MODE_REMOVE, 4'd0, 5'd0, 2'd0, 2'd0, 2'd0, 3'd0, 6'd0, 6'd0, 6'd0,
                       6'd0, 6'd0));

        for (int p = 0; p < PHASES; p++) begin
            drain();
            set_extents(3'(PLAN_W[p]), 3'(PLAN_D[p]), 3'(PLAN_H[p]));
            tx_idle_pct  = (p % 4 == 1) ? 53 : (p % 4 == 3) ? 6 : 0;
            rx_stall_pct = (p % 4 == 2) ? 53 : (p % 4 == 3) ? 6 : 0;
            for (int n = 0; n < PLAN_N[p]; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    r = shape_request(MODE_PUT);
                    placed_log.push_back(r);
                    if (placed_log.size() > HISTORY_MAX)
                        void'(placed_log.pop_front());
                end
                else if (pick < 60) begin
                    r = shape_request(MODE_CHECK);
                end
                else if (pick < 90 && placed_log.size() != 0) begin
                    // Take back an earlier piece, possibly under another owner id.
                    slot = $urandom_range(0, placed_log.size() - 1);
                    r = placed_log[slot];
                    placed_log.delete(slot);
                    r.mode  = MODE_REMOVE;
                    r.piece = 4'($urandom_range(0, 15));
                end
                else begin
                    r = noise_request();
                end
                send(r);
                if ($urandom_range(0, 199) == 0)
                    drain();
            end
        end

        drain();
        $display("covered %0d checks, %0d puts (%0d placed) and %0d removes",
                 shadow.n_check, shadow.n_put, shadow.n_placed, shadow.n_remove);
        $display("over %0d extent settings from zero to above the grid, with gaps and stalls;"
                 , PHASES);
        $display("%0d failures", shadow.failures);
        if (shadow.failures == 0)
            $display("voxel_piece_placement_grid_core regression: pass");
        else
            $display("voxel_piece_placement_grid_core regression: fail");
        $finish;
    end

endmodule
